[sv/plti_pkg.sv]
// shared types and constants for the piecewise linear table interpolator
package plti_pkg;

  localparam int DATA_W    = 32;
  localparam int CHANS     = 3;
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 1;
  localparam int KIDX_W    = 8;

  // input transaction kinds
  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_INTERP = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KNOT_COUNT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHARED_AXIS = 1'd1;

  // control from the top level to one channel unit
  typedef struct packed {
    logic start;
    logic ack;
    logic shared;
    logic wr_en;
  } chan_ctl_t;

endpackage

[sv/plti_chan.sv]
// one channel: knot memories, binary search, weight divider and blend
module plti_chan
  import plti_pkg::*;
#(
  parameter int MAX_KNOTS = 256,
  parameter int FRAC_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  chan_ctl_t                            ctl,
  input  logic [$clog2(MAX_KNOTS+1)-1:0]       n,
  input  logic [$clog2(MAX_KNOTS)-1:0]         wr_addr,
  input  logic signed [DATA_W-1:0]             wr_axis0,
  input  logic signed [DATA_W-1:0]             wr_axis,
  input  logic signed [DATA_W-1:0]             wr_level,
  input  logic signed [DATA_W-1:0]             sample,
  output logic                                 done,
  output logic signed [DATA_W-1:0]             result
);

  localparam int AW   = $clog2(MAX_KNOTS);
  localparam int LW   = $clog2(MAX_KNOTS+1);
  localparam int CNTW = $clog2(FRAC_BITS+1);
  localparam int PW   = FRAC_BITS + 35;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_FIRST = 11'b00000000010,
    S_LAST  = 11'b00000000100,
    S_PROBE = 11'b00000001000,
    S_LO    = 11'b00000010000,
    S_HI    = 11'b00000100000,
    S_PREP  = 11'b00001000000,
    S_DIV   = 11'b00010000000,
    S_MUL   = 11'b00100000000,
    S_SUM   = 11'b01000000000,
    S_DONE  = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;

  // knot storage: axis word holds {channel 0 axis, own axis}
  logic [2*DATA_W-1:0]      axis_mem [MAX_KNOTS];
  logic signed [DATA_W-1:0] level_mem [MAX_KNOTS];
  logic [2*DATA_W-1:0]      axis_q;
  logic signed [DATA_W-1:0] level_q;
  logic signed [DATA_W-1:0] ax;

  logic [AW-1:0]            addr_r, addr_nxt;
  logic [LW-1:0]            lo_r, lo_nxt, hi_r, hi_nxt;
  logic [LW-1:0]            mid_l, lo_p, hi_p, low_l;
  logic signed [DATA_W-1:0] x_r, xl_r, y0_r, res_r;
  logic signed [DATA_W:0]   num_r, den_r, dy_r;
  logic [DATA_W:0]          nmag, dmag, dmag_r;
  logic [DATA_W+1:0]        rem_r, rem2;
  logic                     ge;
  logic [FRAC_BITS-1:0]     q_r;
  logic [FRAC_BITS:0]       t_r;
  logic [CNTW-1:0]          cnt_r;
  logic signed [PW-1:0]     prod_r, shp;
  logic signed [PW:0]       sum_w;

  // knot writes and registered reads
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      axis_mem[wr_addr]  <= {wr_axis0, wr_axis};
      level_mem[wr_addr] <= wr_level;
    end
    axis_q  <= axis_mem[addr_nxt];
    level_q <= level_mem[addr_nxt];
  end

  assign ax = ctl.shared ? $signed(axis_q[2*DATA_W-1:DATA_W]) : $signed(axis_q[DATA_W-1:0]);

  function automatic logic sample_le_first();
    return x_r <= ax;
  endfunction

  // search control and read address
  always_comb begin
    state_nxt = state_r;
    addr_nxt  = addr_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    mid_l     = LW'(addr_r);
    lo_p      = lo_r;
    hi_p      = hi_r;
    low_l     = '0;
    case (state_r)
      S_IDLE: begin
        if (ctl.start) begin
          addr_nxt  = '0;
          state_nxt = (n == '0) ? S_DONE : S_FIRST;
        end
      end
      S_FIRST: begin
        if (n == LW'(1) || sample_le_first()) begin
          state_nxt = S_DONE;
        end else begin
          addr_nxt  = AW'(n - LW'(1));
          state_nxt = S_LAST;
        end
      end
      S_LAST: begin
        if (x_r >= ax) begin
          state_nxt = S_DONE;
        end else begin
          lo_nxt    = '0;
          hi_nxt    = n;
          addr_nxt  = AW'(n >> 1);
          state_nxt = S_PROBE;
        end
      end
      S_PROBE: begin
        if (x_r < ax) begin
          hi_p = mid_l;
        end else begin
          lo_p = mid_l + LW'(1);
        end
        lo_nxt = lo_p;
        hi_nxt = hi_p;
        if (lo_p < hi_p) begin
          addr_nxt = AW'(lo_p + ((hi_p - lo_p) >> 1));
        end else begin
          low_l = (lo_p == '0) ? '0 : lo_p - LW'(1);
          if (low_l > n - LW'(2)) begin
            low_l = n - LW'(2);
          end
          addr_nxt  = AW'(low_l);
          state_nxt = S_LO;
        end
      end
      S_LO: begin
        addr_nxt  = addr_r + AW'(1);
        state_nxt = S_HI;
      end
      S_HI:   state_nxt = S_PREP;
      S_PREP: begin
        if (den_r == '0 || num_r == '0 || num_r[DATA_W] != den_r[DATA_W]) begin
          state_nxt = S_MUL;
        end else if (nmag >= dmag) begin
          state_nxt = S_MUL;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (cnt_r == CNTW'(FRAC_BITS-1)) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL:  state_nxt = S_SUM;
      S_SUM:  state_nxt = S_DONE;
      S_DONE: begin
        if (ctl.ack) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // magnitudes for the weight division
  assign nmag = num_r[DATA_W] ? (DATA_W+1)'(0) - num_r : num_r;
  assign dmag = den_r[DATA_W] ? (DATA_W+1)'(0) - den_r : den_r;

  // one restoring step per cycle
  assign rem2 = {rem_r[DATA_W:0], 1'b0};
  assign ge   = rem2 >= {1'b0, dmag_r};

  // blend and saturate
  assign shp   = prod_r >>> FRAC_BITS;
  assign sum_w = $signed({{(PW-DATA_W+1){y0_r[DATA_W-1]}}, y0_r}) + $signed({shp[PW-1], shp});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    case (state_r)
      S_IDLE: begin
        x_r   <= sample;
        res_r <= '0;
      end
      S_FIRST: res_r <= level_q;
      S_LAST:  res_r <= level_q;
      S_LO: begin
        xl_r  <= ax;
        y0_r  <= level_q;
        num_r <= $signed({x_r[DATA_W-1], x_r}) - $signed({ax[DATA_W-1], ax});
      end
      S_HI: begin
        den_r <= $signed({ax[DATA_W-1], ax}) - $signed({xl_r[DATA_W-1], xl_r});
        dy_r  <= $signed({level_q[DATA_W-1], level_q}) - $signed({y0_r[DATA_W-1], y0_r});
      end
      S_PREP: begin
        rem_r  <= {1'b0, nmag};
        dmag_r <= dmag;
        cnt_r  <= '0;
        q_r    <= '0;
        if (den_r == '0 || num_r == '0 || num_r[DATA_W] != den_r[DATA_W]) begin
          t_r <= '0;
        end else begin
          t_r <= {1'b1, {FRAC_BITS{1'b0}}};
        end
      end
      S_DIV: begin
        rem_r <= ge ? rem2 - {1'b0, dmag_r} : rem2;
        q_r   <= {q_r[FRAC_BITS-2:0], ge};
        cnt_r <= cnt_r + CNTW'(1);
        if (cnt_r == CNTW'(FRAC_BITS-1)) begin
          t_r <= {1'b0, q_r[FRAC_BITS-2:0], ge};
        end
      end
      S_MUL: prod_r <= $signed({1'b0, t_r}) * dy_r;
      S_SUM: begin
        if (sum_w[PW:DATA_W-1] == '0 || sum_w[PW:DATA_W-1] == '1) begin
          res_r <= sum_w[DATA_W-1:0];
        end else if (sum_w[PW]) begin
          res_r <= {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
          res_r <= {1'b0, {(DATA_W-1){1'b1}}};
        end
      end
      default: ;
    endcase
  end

  assign done   = (state_r == S_DONE);
  assign result = res_r;

endmodule

[sv/piecewise_linear_table_interp.sv]
// top level: knot table loader and three-channel clamped linear interpolator
//
// Input channel (in_valid / in_stall) carries two transaction kinds. A write
// transaction (in_action = 0) stores one knot, axis and level for all three
// channels, at in_knot_index and produces no result; it leaves in_stall low.
// An interpolate transaction (in_action = 1) maps one pixel and produces one
// result on the output channel (out_valid / out_stall).
// Per channel a unit reads the first and last knots, runs a binary search of
// up to log2(MAX_KNOTS)+1 probes (one memory read each), reads the two bracket
// knots, divides for the weight one bit per cycle (skipped when the weight
// is 0 or 1) and blends; at a clamped end the level of that end knot is the
// result. The input is freed when the result moves to the output register.
// The three channels run side by side, each on its own memory read port.
// in_stall is high while a pixel is in work. A finished result waits in the
// output register while out_stall is high; the next transaction is taken
// meanwhile, and a new result is held in its unit until the register frees.
// Reset clears control state only: the knot table holds nothing defined
// until written, knot_count is 0 and shared_axis is 1.
module piecewise_linear_table_interp
  import plti_pkg::*;
#(
  parameter int MAX_KNOTS = 256,
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]            cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_action,
  input  logic [KIDX_W-1:0]           in_knot_index,
  input  logic signed [DATA_W-1:0]    in_axis_0,
  input  logic signed [DATA_W-1:0]    in_axis_1,
  input  logic signed [DATA_W-1:0]    in_axis_2,
  input  logic signed [DATA_W-1:0]    in_level_0,
  input  logic signed [DATA_W-1:0]    in_level_1,
  input  logic signed [DATA_W-1:0]    in_level_2,
  input  logic signed [DATA_W-1:0]    in_sample_0,
  input  logic signed [DATA_W-1:0]    in_sample_1,
  input  logic signed [DATA_W-1:0]    in_sample_2,
  input  logic                        in_last_in,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [DATA_W-1:0]    out_0,
  output logic signed [DATA_W-1:0]    out_1,
  output logic signed [DATA_W-1:0]    out_2,
  output logic                        out_last_out
);

  localparam int AW = $clog2(MAX_KNOTS);
  localparam int LW = $clog2(MAX_KNOTS+1);
  localparam int EW = (LW > CFG_W) ? LW : CFG_W;
  localparam int KW = (LW > KIDX_W) ? LW : KIDX_W;

  logic [CFG_W-1:0]         knot_count_r;
  logic                     shared_axis_r;
  logic                     busy_r;
  logic                     last_r;
  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out0_r, out1_r, out2_r;
  logic                     out_last_r;

  logic                     in_acc, wr_en, start, finish;
  logic [LW-1:0]            n;
  logic [AW-1:0]            wr_addr;
  chan_ctl_t                ctl;
  logic [CHANS-1:0]         done;
  logic signed [DATA_W-1:0] res [CHANS];

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      knot_count_r  <= '0;
      shared_axis_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KNOT_COUNT:  knot_count_r  <= cfg_wdata;
        REG_SHARED_AXIS: shared_axis_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // knot count clipped to the table size
  assign n = (EW'(knot_count_r) > EW'(MAX_KNOTS)) ? LW'(MAX_KNOTS) : LW'(knot_count_r);

  assign in_stall = busy_r;
  assign in_acc   = in_valid && !busy_r;
  assign wr_addr  = AW'(in_knot_index);
  assign wr_en    = in_acc && (in_action == ACT_WRITE) &&
                    (KW'(in_knot_index) < KW'(MAX_KNOTS));
  assign start    = in_acc && (in_action == ACT_INTERP);
  assign finish   = busy_r && (&done) && (!out_valid_r || !out_stall);

  assign ctl = '{start: start, ack: finish, shared: shared_axis_r, wr_en: wr_en};

  // channel units
  plti_chan #(.MAX_KNOTS(MAX_KNOTS), .FRAC_BITS(FRAC_BITS)) u_chan0 (
    .clk, .rst_n, .ctl, .n, .wr_addr,
    .wr_axis0(in_axis_0), .wr_axis(in_axis_0), .wr_level(in_level_0),
    .sample(in_sample_0), .done(done[0]), .result(res[0])
  );
  plti_chan #(.MAX_KNOTS(MAX_KNOTS), .FRAC_BITS(FRAC_BITS)) u_chan1 (
    .clk, .rst_n, .ctl, .n, .wr_addr,
    .wr_axis0(in_axis_0), .wr_axis(in_axis_1), .wr_level(in_level_1),
    .sample(in_sample_1), .done(done[1]), .result(res[1])
  );
  plti_chan #(.MAX_KNOTS(MAX_KNOTS), .FRAC_BITS(FRAC_BITS)) u_chan2 (
    .clk, .rst_n, .ctl, .n, .wr_addr,
    .wr_axis0(in_axis_0), .wr_axis(in_axis_2), .wr_level(in_level_2),
    .sample(in_sample_2), .done(done[2]), .result(res[2])
  );

  // busy flag and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (start) begin
        busy_r <= 1'b1;
      end else if (finish) begin
        busy_r <= 1'b0;
      end
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      last_r <= in_last_in;
    end
    if (finish) begin
      out0_r     <= res[0];
      out1_r     <= res[1];
      out2_r     <= res[2];
      out_last_r <= last_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_0        = out0_r;
  assign out_1        = out1_r;
  assign out_2        = out2_r;
  assign out_last_out = out_last_r;

endmodule

[sv/plti_checker.sv]
// port-level checks for the interpolator, bound to the top level
module plti_checker
  import plti_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic                     in_action,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic signed [DATA_W-1:0] out_0,
  input logic signed [DATA_W-1:0] out_1,
  input logic signed [DATA_W-1:0] out_2,
  input logic                     out_last_out
);

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_0) && $stable(out_1) &&
      $stable(out_2) && $stable(out_last_out))
    else $error("stalled result changed");

  // a pixel transaction keeps the input side busy
  a_pixel_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_action == ACT_INTERP |=> in_stall)
    else $error("input not stalled after pixel transaction");

  // a knot write leaves the input side free
  a_write_quick: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_action == ACT_WRITE |=> !in_stall)
    else $error("input stalled after knot write");

  // a new result appears exactly when the pixel work ends
  a_result_end: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $fell(in_stall))
    else $error("result without end of pixel work");

endmodule

bind piecewise_linear_table_interp plti_checker u_plti_checker (
  .clk, .rst_n, .in_valid, .in_stall, .in_action, .out_valid, .out_stall,
  .out_0, .out_1, .out_2, .out_last_out
);
